/* design/sorted_table_insert_and_binary_search_core_defines.svh */
// Assertion helpers for the checker file.
`ifndef SORTED_TABLE_INSERT_AND_BINARY_SEARCH_CORE_DEFINES_SVH
`define SORTED_TABLE_INSERT_AND_BINARY_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STIBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STIBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/stibs_pkg.sv */
package stibs_pkg;

    localparam int DEPTH_DEFAULT = 128;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 7;
    localparam int CNT_W         = 8;
    localparam int OUT_DATA_W    = 24;
    localparam int OUT_PAD_W     = OUT_DATA_W - STATUS_W - POS_W - CNT_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_SR_PROBE,
        S_SR_CMP,
        S_FIN_CMP,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PTR_M1,
        RD_PTR_M2,
        RD_MID,
        RD_LO
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_KEY,
        WR_SHIFT
    } t_wr_sel;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_PTR,
        POS_LO
    } t_pos_sel;

    typedef struct packed {
        logic     cap;
        logic     ptr_load;
        logic     ptr_dec;
        t_rd_sel  rd_sel;
        t_wr_sel  wr_sel;
        logic     bnd_init;
        logic     bnd_step;
        logic     res_load;
        t_status  res_status;
        t_pos_sel res_pos_sel;
        logic     cnt_inc;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic op_search;
        logic full;
        logic empty;
        logic ptr_zero;
        logic ptr_one;
        logic rd_gt;
        logic rd_eq;
        logic probe_more;
        logic out_free;
    } t_dp_stat;

endpackage

/* design/stibs_ctrl.sv */
module stibs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stibs_pkg::t_dp_stat i_stat,
    output stibs_pkg::t_dp_cmd  o_cmd
);

    stibs_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stibs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            stibs_pkg::S_IDLE: begin
                // intake stays closed while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.cap = 1'b1;
                    n_state   = stibs_pkg::S_DISPATCH;
                end
            end
            stibs_pkg::S_DISPATCH: begin
                if (!i_stat.op_search) begin
                    if (i_stat.full) begin
                        o_cmd.res_load    = 1'b1;
                        o_cmd.res_status  = stibs_pkg::ST_FULL;
                        o_cmd.res_pos_sel = stibs_pkg::POS_ZERO;
                        n_state           = stibs_pkg::S_DONE;
                    end else begin
                        o_cmd.ptr_load = 1'b1;
                        n_state        = stibs_pkg::S_INS_RD;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.res_load    = 1'b1;
                        o_cmd.res_status  = stibs_pkg::ST_MISSING;
                        o_cmd.res_pos_sel = stibs_pkg::POS_ZERO;
                        n_state           = stibs_pkg::S_DONE;
                    end else begin
                        o_cmd.bnd_init = 1'b1;
                        n_state        = stibs_pkg::S_SR_PROBE;
                    end
                end
            end
            stibs_pkg::S_INS_RD: begin
                if (i_stat.ptr_zero) begin
                    o_cmd.wr_sel      = stibs_pkg::WR_KEY;
                    o_cmd.res_load    = 1'b1;
                    o_cmd.res_status  = stibs_pkg::ST_INSERTED;
                    o_cmd.res_pos_sel = stibs_pkg::POS_PTR;
                    o_cmd.cnt_inc     = 1'b1;
                    n_state           = stibs_pkg::S_DONE;
                end else begin
                    o_cmd.rd_sel = stibs_pkg::RD_PTR_M1;
                    n_state      = stibs_pkg::S_INS_CMP;
                end
            end
            stibs_pkg::S_INS_CMP: begin
                // read of the next lower entry overlaps the shift write
                if (i_stat.rd_gt) begin
                    o_cmd.wr_sel  = stibs_pkg::WR_SHIFT;
                    o_cmd.ptr_dec = 1'b1;
                    if (i_stat.ptr_one) begin
                        n_state = stibs_pkg::S_INS_RD;
                    end else begin
                        o_cmd.rd_sel = stibs_pkg::RD_PTR_M2;
                    end
                end else begin
                    o_cmd.wr_sel      = stibs_pkg::WR_KEY;
                    o_cmd.res_load    = 1'b1;
                    o_cmd.res_status  = stibs_pkg::ST_INSERTED;
                    o_cmd.res_pos_sel = stibs_pkg::POS_PTR;
                    o_cmd.cnt_inc     = 1'b1;
                    n_state           = stibs_pkg::S_DONE;
                end
            end
            stibs_pkg::S_SR_PROBE: begin
                if (i_stat.probe_more) begin
                    o_cmd.rd_sel = stibs_pkg::RD_MID;
                    n_state      = stibs_pkg::S_SR_CMP;
                end else begin
                    o_cmd.rd_sel = stibs_pkg::RD_LO;
                    n_state      = stibs_pkg::S_FIN_CMP;
                end
            end
            stibs_pkg::S_SR_CMP: begin
                o_cmd.bnd_step = 1'b1;
                n_state        = stibs_pkg::S_SR_PROBE;
            end
            stibs_pkg::S_FIN_CMP: begin
                o_cmd.res_load = 1'b1;
                if (i_stat.rd_eq) begin
                    o_cmd.res_status  = stibs_pkg::ST_FOUND;
                    o_cmd.res_pos_sel = stibs_pkg::POS_LO;
                end else begin
                    o_cmd.res_status  = stibs_pkg::ST_MISSING;
                    o_cmd.res_pos_sel = stibs_pkg::POS_ZERO;
                end
                n_state = stibs_pkg::S_DONE;
            end
            stibs_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = stibs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stibs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/stibs_dp.sv */
module stibs_dp #(
    parameter int TABLE_DEPTH = stibs_pkg::DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  stibs_pkg::t_dp_cmd               i_cmd,
    output stibs_pkg::t_dp_stat              o_stat,
    input  logic                             i_op,
    input  logic signed [stibs_pkg::VALUE_W-1:0] i_value,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output stibs_pkg::t_status               o_status,
    output logic [stibs_pkg::POS_W-1:0]      o_position,
    output logic [stibs_pkg::CNT_W-1:0]      o_entry_count
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int PXW = (AW > stibs_pkg::POS_W) ? AW : stibs_pkg::POS_W;
    localparam int CXW = (CW > stibs_pkg::CNT_W) ? CW : stibs_pkg::CNT_W;

    logic signed [stibs_pkg::VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [stibs_pkg::VALUE_W-1:0] r_rdata;
    logic signed [stibs_pkg::VALUE_W-1:0] r_key;
    logic                                 r_op;
    logic [CW-1:0]                        r_count;
    logic [CW-1:0]                        r_ptr;
    logic [CW-1:0]                        r_lo;
    logic [CW-1:0]                        r_hi;
    logic [CW-1:0]                        r_mid;
    logic                                 r_hit;
    stibs_pkg::t_status                   r_res_status;
    logic [AW-1:0]                        r_res_pos;
    logic                                 r_out_valid;
    stibs_pkg::t_status                   r_out_status;
    logic [stibs_pkg::POS_W-1:0]          r_out_pos;
    logic [stibs_pkg::CNT_W-1:0]          r_out_cnt;

    logic [CW-1:0]                        ptr_m1;
    logic [CW-1:0]                        ptr_m2;
    logic [CW:0]                          bnd_sum;
    logic [CW-1:0]                        mid;
    logic [CW-1:0]                        span;
    logic [AW-1:0]                        rd_addr;
    logic                                 rd_en;
    logic                                 wr_en;
    logic signed [stibs_pkg::VALUE_W-1:0] wr_data;
    logic [PXW-1:0]                       pos_ext;
    logic [CXW-1:0]                       cnt_ext;

    assign ptr_m1  = r_ptr - CW'(1);
    assign ptr_m2  = r_ptr - CW'(2);
    assign bnd_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = bnd_sum[CW:1];
    assign span    = r_hi - r_lo;

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_lo[AW-1:0];
        case (i_cmd.rd_sel)
            stibs_pkg::RD_PTR_M1: rd_addr = ptr_m1[AW-1:0];
            stibs_pkg::RD_PTR_M2: rd_addr = ptr_m2[AW-1:0];
            stibs_pkg::RD_MID:    rd_addr = mid[AW-1:0];
            stibs_pkg::RD_LO:     rd_addr = r_lo[AW-1:0];
            default:              rd_en   = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_data = r_key;
        case (i_cmd.wr_sel)
            stibs_pkg::WR_KEY:   wr_data = r_key;
            stibs_pkg::WR_SHIFT: wr_data = r_rdata;
            default:             wr_en   = 1'b0;
        endcase
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_ptr[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_key <= i_value;
            r_op  <= i_op;
        end
        if (i_cmd.ptr_load) begin
            r_ptr <= r_count;
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= ptr_m1;
        end
        if (i_cmd.rd_sel == stibs_pkg::RD_MID) begin
            r_mid <= mid;
        end
        if (i_cmd.bnd_init) begin
            r_lo  <= '0;
            r_hi  <= r_count;
            r_hit <= 1'b0;
        end else if (i_cmd.bnd_step) begin
            r_hit <= (r_rdata == r_key);
            if (r_rdata > r_key) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid;
            end
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_pos_sel)
                stibs_pkg::POS_PTR: r_res_pos <= r_ptr[AW-1:0];
                stibs_pkg::POS_LO:  r_res_pos <= r_lo[AW-1:0];
                default:            r_res_pos <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end
    end

    // wide depths report position and count modulo the field width
    assign pos_ext = PXW'(r_res_pos);
    assign cnt_ext = CXW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_pos    <= pos_ext[stibs_pkg::POS_W-1:0];
            r_out_cnt    <= cnt_ext[stibs_pkg::CNT_W-1:0];
        end
    end

    assign o_stat.op_search  = (r_op == stibs_pkg::OP_SEARCH);
    assign o_stat.full       = (r_count == CW'(TABLE_DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.ptr_zero   = (r_ptr == '0);
    assign o_stat.ptr_one    = (r_ptr == CW'(1));
    assign o_stat.rd_gt      = (r_rdata > r_key);
    assign o_stat.rd_eq      = (r_rdata == r_key);
    assign o_stat.probe_more = !r_hit && (span > CW'(1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_position    = r_out_pos;
    assign o_entry_count = r_out_cnt;

endmodule

/* design/sorted_table_insert_and_binary_search_core.sv */
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+-------------------------------------------
// s (in)   | in  | i_s_tvalid/o_s_tready  | tdata: value[31:0]; tuser: operation[0]
// m (out)  | out | o_m_tvalid/i_m_tready  | tdata: status[1:0] position[8:2] count[16:9]
//
// insert: one entry shifted per cycle until the new value reaches its position;
// search: at most ceil(log2(held)) probes, each probe a registered memory read;
// a full-table insert or an empty-table search answers without touching the table.
// Reset clears the entry count, the control state and the result valid; the table is not cleared.
// The core holds in its final step only while the previous result is still not taken.
module sorted_table_insert_and_binary_search_core #(
    parameter int TABLE_DEPTH = stibs_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [stibs_pkg::VALUE_W-1:0]       i_s_tdata,  // value[31:0]
    input  logic [0:0]                          i_s_tuser,  // operation[0]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // status[1:0], position[8:2], entry_count[16:9], zero[23:17]
    output logic [stibs_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    stibs_pkg::t_dp_cmd          cmd;
    stibs_pkg::t_dp_stat         stat;
    stibs_pkg::t_status          status;
    logic [stibs_pkg::POS_W-1:0] position;
    logic [stibs_pkg::CNT_W-1:0] entry_count;

    stibs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    stibs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (i_s_tuser[0]),
        .i_value       (i_s_tdata),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_status      (status),
        .o_position    (position),
        .o_entry_count (entry_count)
    );

    assign o_m_tdata = {{stibs_pkg::OUT_PAD_W{1'b0}}, entry_count, position, status};

endmodule

/* design/stibs_chk.sv */
`include "sorted_table_insert_and_binary_search_core_defines.svh"

module stibs_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [stibs_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    logic s_xfer;
    logic m_stall;
    logic no_pos;

    assign s_xfer  = i_s_tvalid && o_s_tready;
    assign m_stall = o_m_tvalid && !i_m_tready;
    assign no_pos  = (o_m_tdata[1:0] == stibs_pkg::ST_FULL)
                     || (o_m_tdata[1:0] == stibs_pkg::ST_MISSING);

    // one operation in flight: intake closes right after a transaction
    `STIBS_ASSERT_NEXT(a_one_in_flight, s_xfer, !o_s_tready, "input taken while busy")

    // drops and misses carry position zero
    `STIBS_ASSERT_NOW(a_pos_zero, o_m_tvalid && no_pos, o_m_tdata[8:2] == '0, "nonzero position")

    `STIBS_ASSERT_NEXT(a_out_hold, m_stall, o_m_tvalid && $stable(o_m_tdata), "stalled result")

endmodule

bind sorted_table_insert_and_binary_search_core stibs_chk u_stibs_chk (.*);

/* tb/sv/tb_sorted_table_insert_and_binary_search_core.sv */
module tb_sorted_table_insert_and_binary_search_core;

    localparam int DEPTH        = stibs_pkg::DEPTH_DEFAULT;
    localparam int VW           = stibs_pkg::VALUE_W;
    localparam int PW           = stibs_pkg::POS_W;
    localparam int CNW          = stibs_pkg::CNT_W;
    localparam int SW           = stibs_pkg::STATUS_W;
    localparam int ODW          = stibs_pkg::OUT_DATA_W;
    localparam int N_RANDOM     = 1800;
    localparam int HOLD_CYCLES  = 500;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        stibs_pkg::t_status st;
        logic [PW-1:0]      pos;
        logic [CNW-1:0]     cnt;
    } t_tbl_result;

    typedef struct packed {
        stibs_pkg::t_op op;
        logic [VW-1:0]  value;
        logic           has_want;
        t_tbl_result    want;
    } t_op_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_s_tvalid = 1'b0;
    logic           o_s_tready;
    logic [VW-1:0]  i_s_tdata = '0;   // value[31:0]
    logic [0:0]     i_s_tuser = '0;   // operation[0]
    logic           o_m_tvalid;
    logic           i_m_tready = 1'b0;
    // status[1:0], position[8:2], entry_count[16:9], zero[23:17]
    logic [ODW-1:0] o_m_tdata;

    // shadow of the table contents
    logic signed [VW-1:0] shadow_vals [DEPTH];
    int unsigned          shadow_count = 0;

    t_tbl_result pending_results[$];
    t_op_row     directed_rows[$];
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;
    int unsigned tx_calm = 0;

    sorted_table_insert_and_binary_search_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one operation to the shadow table and returns what the core must answer.
    function automatic t_tbl_result table_op_outcome(input stibs_pkg::t_op op,
                                                     input logic [VW-1:0] raw);
        t_tbl_result          r;
        logic signed [VW-1:0] v;
        int unsigned          p;
        int unsigned          lo;
        int unsigned          hi;
        int unsigned          mid;
        bit                   hit;
        v = raw;
        r.pos = '0;
        if (op == stibs_pkg::OP_INSERT) begin
            if (shadow_count >= DEPTH) begin
                r.st = stibs_pkg::ST_FULL;
            end else begin
                p = shadow_count;
                while (p > 0 && shadow_vals[p-1] > v) begin
                    shadow_vals[p] = shadow_vals[p-1];
                    p--;
                end
                shadow_vals[p] = v;
                shadow_count++;
                r.st = stibs_pkg::ST_INSERTED;
                r.pos = PW'(p);
            end
        end else if (shadow_count == 0) begin
            r.st = stibs_pkg::ST_MISSING;
        end else begin
            lo = 0;
            hi = shadow_count;
            hit = 1'b0;
            while (!hit && (hi - lo) > 1) begin
                mid = (lo + hi) / 2;
                hit = (shadow_vals[mid] == v);
                if (shadow_vals[mid] > v)
                    hi = mid;
                else
                    lo = mid;
            end
            if (shadow_vals[lo] == v) begin
                r.st = stibs_pkg::ST_FOUND;
                r.pos = PW'(lo);
            end else begin
                r.st = stibs_pkg::ST_MISSING;
            end
        end
        r.cnt = CNW'(shadow_count);
        return r;
    endfunction

    task automatic add_row(input stibs_pkg::t_op op, input logic [VW-1:0] value,
                           input logic has_want, input stibs_pkg::t_status st,
                           input int unsigned pos, input int unsigned cnt);
        t_op_row row;
        row.op = op;
        row.value = value;
        row.has_want = has_want;
        row.want.st = st;
        row.want.pos = PW'(pos);
        row.want.cnt = CNW'(cnt);
        directed_rows.push_back(row);
    endtask

    // Offers one transaction after a random gap and records its expected answer on acceptance.
    task automatic send_op(input stibs_pkg::t_op op, input logic [VW-1:0] value,
                           input logic has_want, input t_tbl_result want);
        t_tbl_result predicted;
        int unsigned gap;
        if (tx_calm != 0) begin
            tx_calm--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            tx_calm = $urandom_range(8, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 19);
        end
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = table_op_outcome(op, value);
        pending_results.push_back(has_want ? want : predicted);
    endtask

    initial begin
        stibs_pkg::t_op op;
        logic [VW-1:0]  value;
        logic [VW-1:0]  base;
        int unsigned    r;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // searches on an empty table, then a few inserts whose answers are obvious
        add_row(stibs_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, stibs_pkg::ST_MISSING, 0, 0);
        add_row(stibs_pkg::OP_SEARCH, 32'h8000_0000, 1'b1, stibs_pkg::ST_MISSING, 0, 0);
        add_row(stibs_pkg::OP_INSERT, 32'h0000_0000, 1'b1, stibs_pkg::ST_INSERTED, 0, 1);
        add_row(stibs_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, stibs_pkg::ST_FOUND, 0, 1);
        add_row(stibs_pkg::OP_SEARCH, 32'h0000_0001, 1'b1, stibs_pkg::ST_MISSING, 0, 1);
        add_row(stibs_pkg::OP_INSERT, 32'h8000_0000, 1'b1, stibs_pkg::ST_INSERTED, 0, 2);
        add_row(stibs_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, stibs_pkg::ST_INSERTED, 2, 3);
        // equal values land after their twins
        add_row(stibs_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, stibs_pkg::ST_INSERTED, 0, 0);
        add_row(stibs_pkg::OP_INSERT, 32'h0000_0000, 1'b0, stibs_pkg::ST_INSERTED, 0, 0);
        add_row(stibs_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, stibs_pkg::ST_INSERTED, 0, 0);
        add_row(stibs_pkg::OP_INSERT, 32'h0000_0001, 1'b0, stibs_pkg::ST_INSERTED, 0, 0);
        add_row(stibs_pkg::OP_INSERT, 32'h5555_5555, 1'b0, stibs_pkg::ST_INSERTED, 0, 0);
        add_row(stibs_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0, stibs_pkg::ST_INSERTED, 0, 0);
        add_row(stibs_pkg::OP_SEARCH, 32'h8000_0000, 1'b0, stibs_pkg::ST_FOUND, 0, 0);
        add_row(stibs_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1'b0, stibs_pkg::ST_FOUND, 0, 0);
        add_row(stibs_pkg::OP_SEARCH, 32'h0000_0000, 1'b0, stibs_pkg::ST_FOUND, 0, 0);
        add_row(stibs_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b0, stibs_pkg::ST_FOUND, 0, 0);
        add_row(stibs_pkg::OP_SEARCH, 32'h5555_5555, 1'b0, stibs_pkg::ST_FOUND, 0, 0);
        add_row(stibs_pkg::OP_SEARCH, 32'hAAAA_AAAA, 1'b0, stibs_pkg::ST_FOUND, 0, 0);
        add_row(stibs_pkg::OP_SEARCH, 32'h0000_0002, 1'b0, stibs_pkg::ST_MISSING, 0, 0);
        add_row(stibs_pkg::OP_SEARCH, 32'h7FFF_FFFE, 1'b0, stibs_pkg::ST_MISSING, 0, 0);
        add_row(stibs_pkg::OP_SEARCH, 32'h8000_0001, 1'b0, stibs_pkg::ST_MISSING, 0, 0);
        add_row(stibs_pkg::OP_INSERT, 32'h0000_0000, 1'b0, stibs_pkg::ST_INSERTED, 0, 0);
        add_row(stibs_pkg::OP_SEARCH, 32'h0000_0000, 1'b0, stibs_pkg::ST_FOUND, 0, 0);

        foreach (directed_rows[k])
            send_op(directed_rows[k].op, directed_rows[k].value,
                    directed_rows[k].has_want, directed_rows[k].want);

        // Sparse inserts so that searches see every fill level; the table fills
        // a little past halfway through, after which inserts are dropped.
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            op = ($urandom_range(0, 99) < 12) ? stibs_pkg::OP_INSERT : stibs_pkg::OP_SEARCH;
            base = (shadow_count != 0) ? shadow_vals[$urandom_range(0, shadow_count - 1)]
                                       : $urandom;
            if (op == stibs_pkg::OP_INSERT) begin
                if (r < 40)
                    value = $urandom;
                else if (r < 70)
                    value = $urandom_range(0, 16) - 32'd8;
                else if (r < 85)
                    value = base;
                else begin
                    case ($urandom_range(0, 3))
                        0: value = 32'h8000_0000;
                        1: value = 32'h7FFF_FFFF;
                        2: value = 32'hFFFF_FFFF;
                        default: value = 32'h0000_0000;
                    endcase
                end
            end else begin
                if (r < 50)
                    value = base;
                else if (r < 70)
                    value = $urandom_range(0, 1) ? base + 32'd1 : base - 32'd1;
                else if (r < 90)
                    value = $urandom;
                else
                    value = $urandom_range(0, 16) - 32'd8;
            end
            send_op(op, value, 1'b0, '0);
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[sorted_table_insert_and_binary_search_core] OK");
        else
            $display("[sorted_table_insert_and_binary_search_core] ERROR");
        $finish;
    end

    // result side: random tready gaps, calm stretches and long hold-offs
    initial begin
        int unsigned wait_cycles;
        int unsigned rx_calm;
        int unsigned taken;
        rx_calm = 0;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (taken == 60 || taken == 1200) begin
                wait_cycles = HOLD_CYCLES;
            end else if (rx_calm != 0) begin
                rx_calm--;
                wait_cycles = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                rx_calm = $urandom_range(8, 40);
                wait_cycles = 0;
            end else begin
                wait_cycles = $urandom_range(0, 19);
            end
            if (wait_cycles != 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        t_tbl_result                   want;
        logic [SW-1:0]                 got_st;
        logic [PW-1:0]                 got_pos;
        logic [CNW-1:0]                got_cnt;
        logic [stibs_pkg::OUT_PAD_W-1:0] got_pad;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_st  = o_m_tdata[SW-1:0];
            got_pos = o_m_tdata[SW+PW-1:SW];
            got_cnt = o_m_tdata[SW+PW+CNW-1:SW+PW];
            got_pad = o_m_tdata[ODW-1:SW+PW+CNW];
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result transaction: tdata=%h", o_m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got_st !== want.st || got_pos !== want.pos || got_cnt !== want.cnt
                        || got_pad !== '0) begin
                    if (mismatches < 10)
                        $display({"result mismatch: exp st=%0d pos=%0d cnt=%0d, ",
                                  "got st=%0d pos=%0d cnt=%0d pad=%h"},
                                 want.st, want.pos, want.cnt, got_st, got_pos, got_cnt,
                                 got_pad);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles without any transaction on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[sorted_table_insert_and_binary_search_core] ERROR");
                $finish;
            end
        end
    end

endmodule
